// ----- sv/ssd_pkg.sv -----
// Shared types and constants for the seven-segment scan driver.
package ssd_pkg;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SCAN  = 1'b1;

    // Result format limits
    localparam int POS_W      = 2;
    localparam int MAX_FRAMES = 4;
    localparam int SEG_W      = 8;
    localparam int FRAME_W    = 16;
    localparam int BIT_CNT_W  = 4;

    // Command queue geometry
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = 1;
    localparam int CMD_CNT_W = 2;

    typedef struct packed {
        logic             req_type;
        logic [POS_W-1:0] digit_index;
        logic [SEG_W-1:0] segment_pattern;
    } request_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_word;
        logic [POS_W-1:0]   frame_position;
        logic               last_frame;
    } frame_t;

    typedef struct packed {
        logic             is_scan;
        logic [POS_W-1:0] index;
        logic [SEG_W-1:0] pattern;
    } cmd_t;

endpackage

// ----- sv/ssd_front.sv -----
// Front end: accept requests, drop out-of-range writes, form commands.
module ssd_front #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic            push,
    output logic            full,
    input  ssd_pkg::request_t request,
    output logic            cmd_push,
    input  logic            cmd_full,
    output ssd_pkg::cmd_t   cmd
);

    localparam logic [ssd_pkg::POS_W:0] LIMIT = (ssd_pkg::POS_W + 1)'(DIGIT_COUNT);

    logic is_scan;
    logic keep;

    // Classify the request
    assign is_scan = (request.req_type == ssd_pkg::REQ_SCAN);
    assign keep    = is_scan || ({1'b0, request.digit_index} < LIMIT);

    // Forward only commands that have an effect
    assign full     = cmd_full;
    assign cmd_push = push && !cmd_full && keep;

    assign cmd.is_scan = is_scan;
    assign cmd.index   = request.digit_index;
    assign cmd.pattern = request.segment_pattern;

endmodule

// ----- sv/ssd_cmd_fifo.sv -----
// Short command queue between front end and scan engine.
module ssd_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  ssd_pkg::cmd_t wr_data,
    output logic          is_full,
    input  logic          rd_en,
    output ssd_pkg::cmd_t rd_data,
    output logic          is_empty
);

    ssd_pkg::cmd_t                  mem_reg [ssd_pkg::CMD_DEPTH];
    logic [ssd_pkg::CMD_PTR_W-1:0]  wr_ptr_reg;
    logic [ssd_pkg::CMD_PTR_W-1:0]  rd_ptr_reg;
    logic [ssd_pkg::CMD_CNT_W-1:0]  count_reg;
    logic [ssd_pkg::CMD_CNT_W-1:0]  count_next;
    logic                           do_wr;
    logic                           do_rd;

    assign is_full  = (count_reg == ssd_pkg::CMD_CNT_W'(ssd_pkg::CMD_DEPTH));
    assign is_empty = (count_reg == '0);
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && !is_empty;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/ssd_back.sv -----
// Scan engine: digit store, serial frame shifter, latch and result register.
module ssd_back #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    input  ssd_pkg::cmd_t cmd,
    output logic          cmd_pop,
    output logic          empty,
    input  logic          pop,
    output ssd_pkg::frame_t frame
);

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [ssd_pkg::POS_W-1:0] LAST_POS = ssd_pkg::POS_W'(DIGIT_COUNT - 1);
    localparam logic [ssd_pkg::SEG_W-1:0] SEL_BASE =
        ssd_pkg::SEG_W'(1 << (DIGIT_COUNT - 1));
    localparam logic [ssd_pkg::BIT_CNT_W-1:0] LAST_BIT =
        ssd_pkg::BIT_CNT_W'(ssd_pkg::FRAME_W - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_LATCH = 2'd2;

    logic [1:0]                      state_reg;
    logic [ssd_pkg::SEG_W-1:0]       store_reg [DIGIT_COUNT];
    logic [ssd_pkg::POS_W-1:0]       scan_start_reg;
    logic [ssd_pkg::POS_W-1:0]       pos_reg;
    logic [ssd_pkg::POS_W-1:0]       frame_cnt_reg;
    logic [ssd_pkg::BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [ssd_pkg::FRAME_W-1:0]     src_reg;
    logic [ssd_pkg::FRAME_W-1:0]     chain_reg;
    logic                            out_valid_reg;
    ssd_pkg::frame_t                 out_reg;

    logic [ssd_pkg::POS_W-1:0]       load_pos;
    logic [ssd_pkg::FRAME_W-1:0]     load_word;
    logic [ssd_pkg::POS_W-1:0]       pos_inc;
    logic                            is_last;
    logic                            out_free;

    // Pick the frame to load: scan start when idle, next position otherwise
    assign pos_inc   = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign load_pos  = (state_reg == ST_IDLE) ? scan_start_reg : pos_inc;
    assign load_word = {store_reg[load_pos[IDX_W-1:0]], SEL_BASE >> load_pos};
    assign is_last   = (frame_cnt_reg == LAST_POS);
    assign out_free  = !out_valid_reg || pop;

    assign cmd_pop = (state_reg == ST_IDLE) && !cmd_empty;
    assign empty   = !out_valid_reg;
    assign frame   = out_reg;

    // Sequence writes and scans
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_start_reg <= '0;
            pos_reg        <= '0;
            frame_cnt_reg  <= '0;
            bit_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!cmd_empty)
                    begin
                        if (cmd.is_scan)
                        begin
                            pos_reg        <= scan_start_reg;
                            frame_cnt_reg  <= '0;
                            bit_cnt_reg    <= '0;
                            scan_start_reg <= (scan_start_reg == LAST_POS) ?
                                              '0 : scan_start_reg + 1'b1;
                            state_reg      <= ST_SHIFT;
                        end
                        else
                        begin
                            store_reg[cmd.index[IDX_W-1:0]] <= cmd.pattern;
                        end
                    end
                end
                ST_SHIFT:
                begin
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == LAST_BIT)
                    begin
                        state_reg <= ST_LATCH;
                    end
                end
                ST_LATCH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (is_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            pos_reg       <= pos_inc;
                            frame_cnt_reg <= frame_cnt_reg + 1'b1;
                            bit_cnt_reg   <= '0;
                            state_reg     <= ST_SHIFT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Shift the frame MSB first into the register chain, latch when full
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE && cmd_pop && cmd.is_scan)
            || (state_reg == ST_LATCH && out_free && !is_last))
        begin
            src_reg <= load_word;
        end
        else if (state_reg == ST_SHIFT)
        begin
            src_reg <= {src_reg[ssd_pkg::FRAME_W-2:0], 1'b0};
        end

        if (state_reg == ST_SHIFT)
        begin
            chain_reg <= {chain_reg[ssd_pkg::FRAME_W-2:0], src_reg[ssd_pkg::FRAME_W-1]};
        end

        if (state_reg == ST_LATCH && out_free)
        begin
            out_reg.frame_word     <= chain_reg;
            out_reg.frame_position <= pos_reg;
            out_reg.last_frame     <= is_last;
        end
    end

endmodule

// ----- sv/seven_segment_scan_driver.sv -----
// Top level: four-digit multiplexed seven-segment scan driver.
// Flow: a write passes through the command queue into the digit store; a scan
// loads each frame into the serial shifter, shifts it into the register chain
// and latches it into the result register, waiting while the previous frame is unpopped.
// The engine takes no new command until the last frame of a scan is latched.
// Reset: digit patterns blank (zero), scan start at position zero, queues empty.
module seven_segment_scan_driver #(
    parameter int NUM_DIGITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  ssd_pkg::request_t request,
    output logic              empty,
    input  logic              pop,
    output ssd_pkg::frame_t   frame
);

    localparam int DIGIT_COUNT = (NUM_DIGITS > ssd_pkg::MAX_FRAMES) ? ssd_pkg::MAX_FRAMES :
                                 (NUM_DIGITS < 1) ? 1 : NUM_DIGITS;
    localparam logic [ssd_pkg::POS_W:0] POS_LIMIT = (ssd_pkg::POS_W + 1)'(DIGIT_COUNT);

    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_pop;
    logic          cmd_empty;
    ssd_pkg::cmd_t cmd_in;
    ssd_pkg::cmd_t cmd_out;

    ssd_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .push     (push),
        .full     (full),
        .request  (request),
        .cmd_push (cmd_push),
        .cmd_full (cmd_full),
        .cmd      (cmd_in)
    );

    ssd_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd_in),
        .is_full  (cmd_full),
        .rd_en    (cmd_pop),
        .rd_data  (cmd_out),
        .is_empty (cmd_empty)
    );

    ssd_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .frame     (frame)
    );

    // The engine never takes a command from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from empty queue");

    // Each frame selects exactly one digit
    a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $onehot(frame.frame_word[7:0]))
        else $error("digit select is not one-hot");

    // Shown position stays within the digit count
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ({1'b0, frame.frame_position} < POS_LIMIT))
        else $error("frame position out of range");

    // Dropped writes never reach the queue
    a_drop_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_push && !cmd_in.is_scan) |-> ({1'b0, cmd_in.index} < POS_LIMIT))
        else $error("out-of-range write queued");

endmodule
